// ----- src/hvt_pkg.sv -----
// Shared types, constants and the saturating arithmetic helper of the hidden Markov model Viterbi tagger.
package hvt_pkg;

	localparam int N_STATES_DEF = 16;
	localparam int N_WORDS_DEF  = 1024;
	localparam int MAX_LEN_DEF  = 64;

	// Widest state index the parameter range allows.
	localparam int STW  = 6;
	// Token counter holds 0 up to the longest sentence.
	localparam int CNTW = 7;

	typedef enum logic [1:0] {
		OP_INIT  = 2'd0,
		OP_TRANS = 2'd1,
		OP_EMIS  = 2'd2,
		OP_TOKEN = 2'd3
	} hvt_op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FEED,
		ST_DRAIN,
		ST_COMMIT,
		ST_FFEED,
		ST_FWAIT,
		ST_TRD,
		ST_TWR,
		ST_ERD,
		ST_EOUT
	} hvt_state_t;

	// One word travelling along the row of cells: a running best candidate
	// for one destination state.
	typedef struct packed {
		logic                vld;
		logic                have;
		logic                zero_tr;
		logic [STW-1:0]      dest;
		logic signed [31:0]  best;
		logic [STW-1:0]      arg;
	} hvt_link_t;

	function automatic logic signed [31:0] hvt_sat(input logic signed [32:0] v);
		logic signed [31:0] r;
		if (v > 33'sh0_7FFF_FFFF) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -33'sh0_8000_0000) begin
			r = -32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

// ----- src/hvt_cell.sv -----
// One predecessor cell: holds a path score and a transition row, and folds its candidate into the passing word.
module hvt_cell #(
	parameter int N_STATES = hvt_pkg::N_STATES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [hvt_pkg::STW-1:0]   idx,
	input  hvt_pkg::hvt_link_t        lin,
	output hvt_pkg::hvt_link_t        lout,
	input  logic                      tr_we,
	input  logic [hvt_pkg::STW-1:0]   tr_waddr,
	input  logic signed [23:0]        tr_wdata,
	input  logic                      sc_load,
	input  logic                      nx_shift,
	input  logic signed [31:0]        nx_in,
	output logic signed [31:0]        nx_out
);

	localparam int SW = $clog2(N_STATES);

	logic signed [23:0] tr_mem [N_STATES];
	logic signed [23:0] tr_rd_q;
	hvt_pkg::hvt_link_t a_q;
	hvt_pkg::hvt_link_t lout_d;
	logic signed [31:0] score_q;
	logic signed [31:0] nxt_q;
	logic signed [31:0] cand;
	logic               take;

	always_ff @(posedge clk) begin
		if (tr_we) begin
			tr_mem[tr_waddr[SW-1:0]] <= tr_wdata;
		end
		tr_rd_q <= tr_mem[lin.dest[SW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q  <= '0;
			lout <= '0;
		end else begin
			a_q  <= lin;
			lout <= lout_d;
		end
	end

	always_comb begin
		if (a_q.zero_tr) begin
			cand = score_q;
		end else begin
			cand = hvt_pkg::hvt_sat(33'(score_q) + 33'(tr_rd_q));
		end
		// Strict greater-than keeps the lower index on a tie.
		take = !a_q.have || (cand > $signed(a_q.best));
		lout_d = a_q;
		if (take) begin
			lout_d.best = cand;
			lout_d.arg  = idx;
		end
		lout_d.have = 1'b1;
	end

	always_ff @(posedge clk) begin
		if (nx_shift) begin
			nxt_q <= nx_in;
		end
		if (sc_load) begin
			score_q <= nxt_q;
		end
	end

	assign nx_out = nxt_q;

endmodule

// ----- src/hmm_viterbi_tagger.sv -----
// Top level of the hidden Markov model Viterbi tagger: table storage, row of cells and sequencer.
//
// The host loads the initial, transition and emission log-probability tables with load
// words and then streams a sentence as token words. The predecessor states form a row of
// N_STATES cells; each cell keeps the previous path score of one state and its transition
// row. For a token, one destination state enters the head of the row every cycle and
// travels from cell to cell, each cell adding its transition term, saturating and keeping
// the larger candidate, so that the lowest index wins a tie. At the tail the emission term
// is added and the new score shifts back into the cells, while the winning predecessor
// goes into the backpointer memory. On the token marked last, one more pass through the
// row finds the best final state, the trace back reads the backpointer memory one
// position at a time, and the tags leave in forward order, held while the output stalls.
// New words are taken only while the block is idle.
module hmm_viterbi_tagger #(
	parameter int N_STATES = hvt_pkg::N_STATES_DEF,
	parameter int N_WORDS  = hvt_pkg::N_WORDS_DEF,
	parameter int MAX_LEN  = hvt_pkg::MAX_LEN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// from_state [3:0], to_state [7:4], word [17:8], log_prob [41:18], zero [47:42]
	input  logic [47:0] s_tdata,
	// opcode [1:0]
	input  logic [1:0]  s_tuser,
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	// tag [3:0], position [9:4], zero [15:10]
	output logic [15:0] m_tdata,
	// truncated [0]
	output logic        m_tuser,
	output logic        m_tlast
);

	localparam int STW  = hvt_pkg::STW;
	localparam int CNTW = hvt_pkg::CNTW;
	localparam int SW   = $clog2(N_STATES);
	localparam int EMW  = $clog2(N_STATES * N_WORDS);
	localparam int BPW  = $clog2(MAX_LEN * N_STATES);
	localparam int PBW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

	// Input word fields.
	logic [3:0]         in_fs;
	logic [3:0]         in_ts;
	logic [9:0]         in_word;
	logic signed [23:0] in_lp;
	logic               acc;
	logic               fs_ok;
	logic               ts_ok;
	logic               w_ok;

	assign in_fs   = s_tdata[3:0];
	assign in_ts   = s_tdata[7:4];
	assign in_word = s_tdata[17:8];
	assign in_lp   = $signed(s_tdata[41:18]);
	assign acc     = s_tvalid && s_tready;
	assign fs_ok   = 7'(in_fs) < 7'(N_STATES);
	assign ts_ok   = 7'(in_ts) < 7'(N_STATES);
	assign w_ok    = 17'(in_word) < 17'(N_WORDS);

	logic init_we;
	logic tr_we;
	logic em_we;

	assign init_we = acc && (s_tuser == hvt_pkg::OP_INIT) && fs_ok;
	assign tr_we   = acc && (s_tuser == hvt_pkg::OP_TRANS) && fs_ok && ts_ok;
	assign em_we   = acc && (s_tuser == hvt_pkg::OP_EMIS) && fs_ok && w_ok;

	// Sequencer state and counters.
	hvt_pkg::hvt_state_t st_q, st_d;
	logic [CNTW-1:0] count_q;
	logic            ovf_q;
	logic            last_q;
	logic            first_q;
	logic [9:0]      word_q;
	logic [SW-1:0]   feed_q;
	logic [SW-1:0]   res_q;
	logic [CNTW-1:0] idx_q;
	logic [STW-1:0]  cur_q;
	logic [CNTW-1:0] pos_q;

	// Row of cells.
	hvt_pkg::hvt_link_t lk [N_STATES+1];
	logic signed [31:0] nx [N_STATES+1];
	hvt_pkg::hvt_link_t head_lk;
	hvt_pkg::hvt_link_t e1_q;
	logic               sc_load;
	logic               nx_shift;
	logic               feed_vld;
	logic               feed_zero;

	always_comb begin
		head_lk         = '0;
		head_lk.vld     = feed_vld;
		head_lk.zero_tr = feed_zero;
		head_lk.dest    = STW'(feed_q);
	end

	assign lk[0] = head_lk;

	for (genvar p = 0; p < N_STATES; p++) begin : g_cell
		hvt_cell #(
			.N_STATES(N_STATES)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.idx     (STW'(p)),
			.lin     (lk[p]),
			.lout    (lk[p+1]),
			.tr_we   (tr_we && (7'(in_fs) == 7'(p))),
			.tr_waddr(STW'(in_ts)),
			.tr_wdata(in_lp),
			.sc_load (sc_load),
			.nx_shift(nx_shift),
			.nx_in   (nx[p+1]),
			.nx_out  (nx[p])
		);
	end

	// Tables read at the tail of the row.
	logic signed [23:0] init_mem [N_STATES];
	logic signed [23:0] em_mem [N_STATES*N_WORDS];
	logic signed [23:0] init_rd_q;
	logic signed [23:0] em_rd_q;
	logic [22:0]        em_waddr_w;
	logic [22:0]        em_raddr_w;

	assign em_waddr_w = 23'(in_fs) * 23'(N_WORDS) + 23'(in_word);
	assign em_raddr_w = 23'(lk[N_STATES].dest) * 23'(N_WORDS) + 23'(word_q);

	always_ff @(posedge clk) begin
		if (init_we) begin
			init_mem[in_fs[SW-1:0]] <= in_lp;
		end
		init_rd_q <= init_mem[lk[N_STATES].dest[SW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (em_we) begin
			em_mem[em_waddr_w[EMW-1:0]] <= in_lp;
		end
		em_rd_q <= em_mem[em_raddr_w[EMW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e1_q <= '0;
		end else begin
			e1_q <= lk[N_STATES];
		end
	end

	// New score of the destination at the tail; the first token starts from the initial table.
	logic signed [31:0] base;

	assign base         = first_q ? 32'(init_rd_q) : $signed(e1_q.best);
	assign nx[N_STATES] = hvt_pkg::hvt_sat(33'(base) + 33'(em_rd_q));
	assign nx_shift     = e1_q.vld && !e1_q.zero_tr;

	// Backpointer memory, one entry per position and state.
	logic [STW-1:0] bp_mem [MAX_LEN*N_STATES];
	logic [STW-1:0] bp_rd_q;
	logic [12:0]    bp_waddr_w;
	logic [12:0]    bp_raddr_w;
	logic           bp_re;

	assign bp_waddr_w = 13'(count_q) * 13'(N_STATES) + 13'(e1_q.dest);
	assign bp_raddr_w = 13'(idx_q) * 13'(N_STATES) + 13'(cur_q);

	always_ff @(posedge clk) begin
		if (nx_shift && !first_q) begin
			bp_mem[bp_waddr_w[BPW-1:0]] <= e1_q.arg;
		end
		if (bp_re) begin
			bp_rd_q <= bp_mem[bp_raddr_w[BPW-1:0]];
		end
	end

	// Path buffer filled by the trace back and read out in forward order.
	logic [STW-1:0]  pb_mem [MAX_LEN];
	logic [STW-1:0]  pb_rd_q;
	logic            pb_we;
	logic [CNTW-1:0] pb_waddr;
	logic [STW-1:0]  pb_wdata;
	logic            pb_re;

	always_ff @(posedge clk) begin
		if (pb_we) begin
			pb_mem[pb_waddr[PBW-1:0]] <= pb_wdata;
		end
		if (pb_re) begin
			pb_rd_q <= pb_mem[pos_q[PBW-1:0]];
		end
	end

	logic fin_hit;
	logic last_pos;

	assign fin_hit  = e1_q.vld && e1_q.zero_tr;
	assign last_pos = (pos_q == count_q - CNTW'(1));

	// Next state and control outputs.
	always_comb begin
		st_d      = st_q;
		s_tready  = 1'b0;
		feed_vld  = 1'b0;
		feed_zero = 1'b0;
		sc_load   = 1'b0;
		bp_re     = 1'b0;
		pb_we     = 1'b0;
		pb_waddr  = idx_q;
		pb_wdata  = bp_rd_q;
		pb_re     = 1'b0;
		m_tvalid  = 1'b0;
		case (st_q)
			hvt_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (acc && (s_tuser == hvt_pkg::OP_TOKEN)) begin
					if (count_q < CNTW'(MAX_LEN)) begin
						st_d = hvt_pkg::ST_FEED;
					end else if (s_tlast) begin
						st_d = hvt_pkg::ST_FFEED;
					end
				end
			end
			hvt_pkg::ST_FEED: begin
				feed_vld = 1'b1;
				if (feed_q == SW'(N_STATES - 1)) begin
					st_d = hvt_pkg::ST_DRAIN;
				end
			end
			hvt_pkg::ST_DRAIN: begin
				if (nx_shift && (res_q == SW'(N_STATES - 1))) begin
					st_d = hvt_pkg::ST_COMMIT;
				end
			end
			hvt_pkg::ST_COMMIT: begin
				sc_load = 1'b1;
				st_d    = last_q ? hvt_pkg::ST_FFEED : hvt_pkg::ST_IDLE;
			end
			hvt_pkg::ST_FFEED: begin
				feed_vld  = 1'b1;
				feed_zero = 1'b1;
				st_d      = hvt_pkg::ST_FWAIT;
			end
			hvt_pkg::ST_FWAIT: begin
				if (fin_hit) begin
					pb_we    = 1'b1;
					pb_waddr = count_q - CNTW'(1);
					pb_wdata = e1_q.arg;
					st_d     = hvt_pkg::ST_TRD;
				end
			end
			hvt_pkg::ST_TRD: begin
				if (idx_q == '0) begin
					st_d = hvt_pkg::ST_ERD;
				end else begin
					bp_re = 1'b1;
					st_d  = hvt_pkg::ST_TWR;
				end
			end
			hvt_pkg::ST_TWR: begin
				pb_we    = 1'b1;
				pb_waddr = idx_q - CNTW'(1);
				st_d     = hvt_pkg::ST_TRD;
			end
			hvt_pkg::ST_ERD: begin
				pb_re = 1'b1;
				st_d  = hvt_pkg::ST_EOUT;
			end
			hvt_pkg::ST_EOUT: begin
				m_tvalid = 1'b1;
				if (m_tready) begin
					st_d = last_pos ? hvt_pkg::ST_IDLE : hvt_pkg::ST_ERD;
				end
			end
			default: begin
				st_d = hvt_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= hvt_pkg::ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
			last_q  <= 1'b0;
			first_q <= 1'b0;
			word_q  <= '0;
			feed_q  <= '0;
			res_q   <= '0;
			idx_q   <= '0;
			cur_q   <= '0;
			pos_q   <= '0;
		end else begin
			if (st_q == hvt_pkg::ST_IDLE && acc && (s_tuser == hvt_pkg::OP_TOKEN)) begin
				last_q  <= s_tlast;
				first_q <= (count_q == '0);
				word_q  <= w_ok ? in_word : 10'd0;
				feed_q  <= '0;
				res_q   <= '0;
				if (count_q >= CNTW'(MAX_LEN)) begin
					ovf_q <= 1'b1;
				end
			end
			if (feed_vld) begin
				feed_q <= feed_q + SW'(1);
			end
			if (nx_shift) begin
				res_q <= res_q + SW'(1);
			end
			if (sc_load) begin
				count_q <= count_q + CNTW'(1);
			end
			if (st_q == hvt_pkg::ST_FWAIT && fin_hit) begin
				cur_q <= e1_q.arg;
				idx_q <= count_q - CNTW'(1);
				pos_q <= '0;
			end
			if (st_q == hvt_pkg::ST_TWR) begin
				cur_q <= bp_rd_q;
				idx_q <= idx_q - CNTW'(1);
			end
			if (st_q == hvt_pkg::ST_EOUT && m_tready) begin
				if (last_pos) begin
					count_q <= '0;
					ovf_q   <= 1'b0;
				end else begin
					pos_q <= pos_q + CNTW'(1);
				end
			end
		end
	end

	assign m_tdata = {6'd0, 6'(pos_q), 4'(pb_rd_q)};
	assign m_tlast = last_pos;
	assign m_tuser = ovf_q;

endmodule

// ----- src/hvt_checker.sv -----
// Port-level assertions for the Viterbi tagger and the bind that attaches them.
module hvt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic        m_tlast
);

	// A stalled output word holds its value.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output word changed while stalled");

	// No input is taken while a tag is pending.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("input accepted while a tag is pending");

	// After the final tag of a path the block goes idle.
	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |=> !m_tvalid && s_tready)
		else $error("block not idle after the end of a path");

	// Unused output bits stay zero.
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[15:10] == 6'd0))
		else $error("output padding not zero");

endmodule

bind hmm_viterbi_tagger hvt_checker u_hvt_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tlast (m_tlast)
);
